// File: rtl/core/xxh64_pkg.sv
// shared constants, item type and helpers of the xxhash64 stream hasher
package xxh64_pkg;

	localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
	localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

	// item classes decided by the front
	localparam logic [1:0] OP_BUF = 2'd0;
	localparam logic [1:0] OP_ABS = 2'd1;
	localparam logic [1:0] OP_FIN = 2'd2;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic [1:0]  op;
		logic        first;
	} item_t;

	// rotate left by a nonzero constant amount
	function automatic logic [63:0] rotl64(input logic [63:0] v, input int n);
		return (v << n) | (v >> (64 - n));
	endfunction

endpackage

// File: rtl/core/xxh64_front.sv
// front: accepts input transactions and classifies them for the back
module xxh64_front import xxh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	input  logic        q_full,
	output logic        push,
	output item_t       item
);

	logic       first_q;
	logic [1:0] phase_q;

	assign push = in_valid && !q_full;

	// classify and saturate the byte count
	always_comb begin
		item.word  = data_word;
		item.first = first_q;
		if (!last_word) begin
			item.cnt = 4'd8;
			item.op  = (phase_q == 2'd3) ? OP_ABS : OP_BUF;
		end else begin
			item.cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;
			item.op  = OP_FIN;
		end
	end

	// message position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			phase_q <= 2'd0;
		end else if (push) begin
			if (last_word) begin
				first_q <= 1'b1;
				phase_q <= 2'd0;
			end else begin
				first_q <= 1'b0;
				phase_q <= phase_q + 2'd1;
			end
		end
	end

endmodule

// File: rtl/core/xxh64_queue.sv
// two-entry queue between front and back
module xxh64_queue import xxh64_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  q_valid,
	output item_t q_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/core/xxh64_mul.sv
// 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle
module xxh64_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p,
	output logic        done
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] p_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;

	// partial product select: lo*lo, lo*hi, hi*lo
	assign ma   = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign mb   = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	assign prod = {32'd0, ma} * {32'd0, mb};
	assign p    = p_q;
	assign done = done_q;

	// operands and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				p_q <= prod;
			end else begin
				p_q <= p_q + {prod[31:0], 32'd0};
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= 2'd0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd2) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/xxh64_back.sv
// back: lane absorb, finishing sequence and result register
module xxh64_back import xxh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] seed,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        pop,
	output logic        mul_start,
	output logic [63:0] mul_a,
	output logic [63:0] mul_b,
	input  logic [63:0] mul_p,
	input  logic        mul_done,
	output logic        out_valid,
	output logic [63:0] hash_value,
	input  logic        out_stall
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_DISP = 5'd1;
	localparam logic [4:0] ST_AB1  = 5'd2;
	localparam logic [4:0] ST_AB2  = 5'd3;
	localparam logic [4:0] ST_FIN0 = 5'd4;
	localparam logic [4:0] ST_FL1  = 5'd5;
	localparam logic [4:0] ST_FL2  = 5'd6;
	localparam logic [4:0] ST_FL3  = 5'd7;
	localparam logic [4:0] ST_ADDT = 5'd8;
	localparam logic [4:0] ST_TCHK = 5'd9;
	localparam logic [4:0] ST_TW1  = 5'd10;
	localparam logic [4:0] ST_TW2  = 5'd11;
	localparam logic [4:0] ST_TW3  = 5'd12;
	localparam logic [4:0] ST_Q1   = 5'd13;
	localparam logic [4:0] ST_Q2   = 5'd14;
	localparam logic [4:0] ST_BCHK = 5'd15;
	localparam logic [4:0] ST_B1   = 5'd16;
	localparam logic [4:0] ST_B2   = 5'd17;
	localparam logic [4:0] ST_AV0  = 5'd18;
	localparam logic [4:0] ST_AV1  = 5'd19;
	localparam logic [4:0] ST_AV2  = 5'd20;
	localparam logic [4:0] ST_OUT  = 5'd21;

	logic [4:0]  st_q;
	logic [63:0] acc_q [4];
	logic [63:0] pend_q [3];
	logic [1:0]  pcnt_q;
	logic [63:0] len_q;
	logic        any_q;
	logic [63:0] w_q;
	logic [3:0]  cnt_q;
	logic [1:0]  op_q;
	logic [63:0] total_q;
	logic [63:0] h_q;
	logic [1:0]  k_q;
	logic [3:0]  bi_q;
	logic        fin_q;
	logic        ms_q;
	logic        out_valid_q;
	logic [63:0] hash_q;
	logic [63:0] wsel;
	logic [63:0] tsrc;
	logic [63:0] acc_sel;
	logic [7:0]  byte_sel;
	logic        is_mul;

	assign pop        = (st_q == ST_IDLE) && q_valid;
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;
	assign acc_sel    = acc_q[k_q];

	// word selects for stripe and tail steps
	always_comb begin
		case (k_q)
			2'd0:    wsel = pend_q[0];
			2'd1:    wsel = pend_q[1];
			2'd2:    wsel = pend_q[2];
			default: wsel = w_q;
		endcase
		tsrc     = (k_q < pcnt_q) ? wsel : w_q;
		byte_sel = 8'(w_q >> {bi_q[2:0], 3'b000});
	end

	// multiplier operand feed
	always_comb begin
		is_mul = 1'b1;
		mul_a  = 64'd0;
		mul_b  = 64'd0;
		unique case (st_q)
			ST_AB1: begin mul_a = wsel; mul_b = PR2; end
			ST_AB2: begin mul_a = rotl64(acc_sel + mul_p, 31); mul_b = PR1; end
			ST_FL1: begin mul_a = acc_sel; mul_b = PR2; end
			ST_FL2: begin mul_a = rotl64(mul_p, 31); mul_b = PR1; end
			ST_FL3: begin mul_a = h_q; mul_b = PR1; end
			ST_TW1: begin mul_a = tsrc; mul_b = PR2; end
			ST_TW2: begin mul_a = rotl64(mul_p, 31); mul_b = PR1; end
			ST_TW3: begin mul_a = rotl64(h_q, 27); mul_b = PR1; end
			ST_Q1:  begin mul_a = {32'd0, w_q[31:0]}; mul_b = PR1; end
			ST_Q2:  begin mul_a = rotl64(h_q, 23); mul_b = PR2; end
			ST_B1:  begin mul_a = {56'd0, byte_sel}; mul_b = PR5; end
			ST_B2:  begin mul_a = rotl64(h_q, 11); mul_b = PR1; end
			ST_AV1: begin mul_a = h_q; mul_b = PR2; end
			ST_AV2: begin mul_a = h_q; mul_b = PR3; end
			default: is_mul = 1'b0;
		endcase
	end

	assign mul_start = is_mul && !ms_q;

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			w_q  <= q_item.word;
			cnt_q <= q_item.cnt;
			op_q <= q_item.op;
			if (q_item.first) begin
				acc_q[0] <= seed + PR1 + PR2;
				acc_q[1] <= seed + PR2;
				acc_q[2] <= seed;
				acc_q[3] <= seed - PR1;
			end
		end
		if (st_q == ST_DISP && op_q == OP_BUF) begin
			case (pcnt_q)
				2'd0:    pend_q[0] <= w_q;
				2'd1:    pend_q[1] <= w_q;
				default: pend_q[2] <= w_q;
			endcase
		end
		if (st_q == ST_DISP && op_q == OP_FIN) begin
			total_q <= len_q + {60'd0, cnt_q};
			if (cnt_q == 4'd8 && pcnt_q == 2'd3) begin
				cnt_q <= 4'd0;
			end
		end
		if (st_q == ST_AB2 && ms_q && mul_done) begin
			acc_q[k_q] <= mul_p;
		end
		// running hash
		case (st_q)
			ST_FIN0: h_q <= any_q ? (rotl64(acc_q[0], 1) + rotl64(acc_q[1], 7)
			                       + rotl64(acc_q[2], 12) + rotl64(acc_q[3], 18))
			                      : (acc_q[2] + PR5);
			ST_ADDT: h_q <= h_q + total_q;
			ST_AV0:  h_q <= h_q ^ (h_q >> 33);
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					hash_q <= h_q;
				end
			end
			default: begin
				if (ms_q && mul_done) begin
					case (st_q)
						ST_FL2, ST_TW2, ST_Q1, ST_B1: h_q <= h_q ^ mul_p;
						ST_FL3, ST_TW3:               h_q <= mul_p + PR4;
						ST_Q2:                        h_q <= mul_p + PR3;
						ST_B2:                        h_q <= mul_p;
						ST_AV1:                       h_q <= mul_p ^ (mul_p >> 29);
						ST_AV2:                       h_q <= mul_p ^ (mul_p >> 32);
						default:                      h_q <= h_q;
					endcase
				end
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pcnt_q      <= 2'd0;
			len_q       <= 64'd0;
			any_q       <= 1'b0;
			k_q         <= 2'd0;
			bi_q        <= 4'd0;
			fin_q       <= 1'b0;
			ms_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && st_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (is_mul) begin
				if (!ms_q) begin
					ms_q <= 1'b1;
				end else if (mul_done) begin
					ms_q <= 1'b0;
				end
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.first) begin
							pcnt_q <= 2'd0;
							len_q  <= 64'd0;
							any_q  <= 1'b0;
						end
						st_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					k_q   <= 2'd0;
					fin_q <= 1'b0;
					unique case (op_q)
						OP_BUF: begin
							len_q  <= len_q + 64'd8;
							pcnt_q <= pcnt_q + 2'd1;
							st_q   <= ST_IDLE;
						end
						OP_ABS: begin
							len_q <= len_q + 64'd8;
							st_q  <= ST_AB1;
						end
						default: begin
							if (cnt_q == 4'd8 && pcnt_q == 2'd3) begin
								fin_q <= 1'b1;
								st_q  <= ST_AB1;
							end else begin
								st_q <= ST_FIN0;
							end
						end
					endcase
				end
				ST_AB1: if (ms_q && mul_done) st_q <= ST_AB2;
				ST_AB2: begin
					if (ms_q && mul_done) begin
						if (k_q == 2'd3) begin
							pcnt_q <= 2'd0;
							any_q  <= 1'b1;
							st_q   <= fin_q ? ST_FIN0 : ST_IDLE;
						end else begin
							k_q  <= k_q + 2'd1;
							st_q <= ST_AB1;
						end
					end
				end
				ST_FIN0: begin
					k_q  <= 2'd0;
					st_q <= any_q ? ST_FL1 : ST_ADDT;
				end
				ST_FL1: if (ms_q && mul_done) st_q <= ST_FL2;
				ST_FL2: if (ms_q && mul_done) st_q <= ST_FL3;
				ST_FL3: begin
					if (ms_q && mul_done) begin
						if (k_q == 2'd3) begin
							st_q <= ST_ADDT;
						end else begin
							k_q  <= k_q + 2'd1;
							st_q <= ST_FL1;
						end
					end
				end
				ST_ADDT: begin
					k_q  <= 2'd0;
					st_q <= ST_TCHK;
				end
				ST_TCHK: begin
					if (k_q < pcnt_q || cnt_q == 4'd8) begin
						st_q <= ST_TW1;
					end else if (cnt_q >= 4'd4) begin
						st_q <= ST_Q1;
					end else begin
						bi_q <= 4'd0;
						st_q <= ST_BCHK;
					end
				end
				ST_TW1: if (ms_q && mul_done) st_q <= ST_TW2;
				ST_TW2: if (ms_q && mul_done) st_q <= ST_TW3;
				ST_TW3: begin
					if (ms_q && mul_done) begin
						if (k_q < pcnt_q) begin
							k_q  <= k_q + 2'd1;
							st_q <= ST_TCHK;
						end else begin
							bi_q <= 4'd8;
							st_q <= ST_BCHK;
						end
					end
				end
				ST_Q1: if (ms_q && mul_done) st_q <= ST_Q2;
				ST_Q2: begin
					if (ms_q && mul_done) begin
						bi_q <= 4'd4;
						st_q <= ST_BCHK;
					end
				end
				ST_BCHK: st_q <= (bi_q < cnt_q) ? ST_B1 : ST_AV0;
				ST_B1: if (ms_q && mul_done) st_q <= ST_B2;
				ST_B2: begin
					if (ms_q && mul_done) begin
						bi_q <= bi_q + 4'd1;
						st_q <= ST_BCHK;
					end
				end
				ST_AV0: st_q <= ST_AV1;
				ST_AV1: if (ms_q && mul_done) st_q <= ST_AV2;
				ST_AV2: if (ms_q && mul_done) st_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						pcnt_q      <= 2'd0;
						len_q       <= 64'd0;
						any_q       <= 1'b0;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// a product only arrives after this block asked for one
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> ms_q) else $error("multiplier result without request");

	// stripe absorb only runs with three buffered words
	a_abs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_AB1 || st_q == ST_AB2) |-> pcnt_q == 2'd3)
		else $error("stripe absorb with short buffer");

	// a popped transaction is dispatched next
	a_pop_disp: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> st_q == ST_DISP) else $error("pop not followed by dispatch");

endmodule

// File: rtl/core/xxhash64_stream_hasher.sv
// top level of the xxhash64 stream hasher: front, queue, back, multiplier
// each 64-bit multiply runs on one shared 32x32 multiplier (3 partial products)
// buffered word: stored only, no multiply; stripe-completing word: 8 multiplies
// last word adds the finish multiplies: up to 12 lane-fold, 3 per tail word, 2 per 4/1-byte step, 2 avalanche
// two-entry queue lets the input take words while the finishing sequence runs
// reset clears queue, sequencer, seed (to 0) and result valid at once; no clearing pass
module xxhash64_stream_hasher import xxh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] seed_value,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	logic [63:0] seed_q;
	logic        push;
	item_t       push_item;
	logic        q_full;
	logic        q_valid;
	item_t       q_item;
	logic        pop;
	logic        mul_start;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic [63:0] mul_p;
	logic        mul_done;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= seed_value;
		end
	end

	xxh64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.q_full     (q_full),
		.push       (push),
		.item       (push_item)
	);

	xxh64_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	xxh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.done   (mul_done)
	);

	xxh64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.mul_start  (mul_start),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.mul_p      (mul_p),
		.mul_done   (mul_done),
		.out_valid  (out_valid),
		.hash_value (hash_value),
		.out_stall  (out_stall)
	);

endmodule

// File: tb/sv/tb_xxhash64_stream_hasher.sv
// self-checking testbench for the xxhash64 stream hasher
module tb_xxhash64_stream_hasher;
	import xxh64_pkg::*;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        last;
	} word_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] seed_value;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_word;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] hash_value;

	xxhash64_stream_hasher dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed_value (seed_value),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	localparam int SETTLE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 20000;

	word_item_t  word_q[$];
	logic [63:0] hash_q[$];
	word_item_t  on_bus;
	int          error_count = 0;
	int          idle_cycles = 0;
	int          in_gap = 0;
	int          no_idle = 0;
	bit          hold_input = 0;

	// shadow hasher state
	logic [63:0] sh_seed = '0;
	logic [63:0] sh_lane[4];
	logic [63:0] sh_pend[3];
	int          sh_pcnt = 0;
	logic [63:0] sh_len = '0;
	bit          sh_in_msg = 0;
	bit          sh_stripe = 0;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] rol(input logic [63:0] v, input int n);
		return (v << n) | (v >> (64 - n));
	endfunction

	function automatic logic [63:0] round_mix(input logic [63:0] acc, input logic [63:0] w);
		logic [63:0] a;
		a = acc + w * PR2;
		return rol(a, 31) * PR1;
	endfunction

	function automatic logic [63:0] fold_tail_word(input logic [63:0] h, input logic [63:0] w);
		logic [63:0] x;
		x = h ^ round_mix(64'd0, w);
		return rol(x, 27) * PR1 + PR4;
	endfunction

	task automatic absorb_stripe(input logic [63:0] w3);
		sh_lane[0] = round_mix(sh_lane[0], sh_pend[0]);
		sh_lane[1] = round_mix(sh_lane[1], sh_pend[1]);
		sh_lane[2] = round_mix(sh_lane[2], sh_pend[2]);
		sh_lane[3] = round_mix(sh_lane[3], w3);
		sh_pcnt = 0;
		sh_stripe = 1;
	endtask

	// advance the shadow hasher by one word, queue the hash on a last word
	task automatic hash_word(input word_item_t it);
		logic [63:0] h;
		logic [63:0] total;
		int          cnt;
		int          i;
		if (!sh_in_msg) begin
			sh_lane[0] = sh_seed + PR1 + PR2;
			sh_lane[1] = sh_seed + PR2;
			sh_lane[2] = sh_seed;
			sh_lane[3] = sh_seed - PR1;
			sh_pcnt = 0;
			sh_len = '0;
			sh_stripe = 0;
			sh_in_msg = 1;
		end
		if (!it.last) begin
			sh_len = sh_len + 64'd8;
			if (sh_pcnt >= 3)
				absorb_stripe(it.word);
			else begin
				sh_pend[sh_pcnt] = it.word;
				sh_pcnt++;
			end
			return;
		end
		cnt = (it.cnt > 8) ? 8 : int'(it.cnt);
		total = sh_len + 64'(cnt);
		if (cnt == 8 && sh_pcnt >= 3) begin
			absorb_stripe(it.word);
			cnt = 0;
		end
		if (sh_stripe) begin
			h = rol(sh_lane[0], 1) + rol(sh_lane[1], 7) + rol(sh_lane[2], 12)
				+ rol(sh_lane[3], 18);
			for (i = 0; i < 4; i++) begin
				h = h ^ round_mix(64'd0, sh_lane[i]);
				h = h * PR1 + PR4;
			end
		end else begin
			h = sh_lane[2] + PR5;
		end
		h = h + total;
		for (i = 0; i < sh_pcnt; i++)
			h = fold_tail_word(h, sh_pend[i]);
		i = 0;
		if (cnt == 8) begin
			h = fold_tail_word(h, it.word);
			i = 8;
		end else if (cnt >= 4) begin
			h = h ^ ({32'd0, it.word[31:0]} * PR1);
			h = rol(h, 23) * PR2 + PR3;
			i = 4;
		end
		for (; i < cnt; i++) begin
			h = h ^ ({56'd0, it.word[8*i +: 8]} * PR5);
			h = rol(h, 11) * PR1;
		end
		h = h ^ (h >> 33);
		h = h * PR2;
		h = h ^ (h >> 29);
		h = h * PR3;
		h = h ^ (h >> 32);
		sh_pcnt = 0;
		sh_len = '0;
		sh_in_msg = 0;
		sh_stripe = 0;
		hash_q.push_back(h);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle != 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_word <= '0;
			byte_count <= '0;
			last_word <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				hash_word(on_bus);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (word_q.size() > 0 && !hold_input) begin
					on_bus = word_q.pop_front();
					data_word <= on_bus.word;
					byte_count <= on_bus.cnt;
					last_word <= on_bus.last;
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (hash_q.size() == 0)
					report_mismatch($sformatf("unexpected hash %h", hash_value));
				else begin
					if (hash_value !== hash_q[0])
						report_mismatch($sformatf("hash %h, want %h", hash_value, hash_q[0]));
					void'(hash_q.pop_front());
				end
			end
			out_stall <= (pick_gap() > 0);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("xxhash64_stream_hasher regression: fail");
			$finish;
		end
	end

	task automatic push_word(input logic [63:0] w, input logic [3:0] c, input logic l);
		word_item_t it;
		it.word = w;
		it.cnt = c;
		it.last = l;
		word_q.push_back(it);
	endtask

	// message of n full words then a last word with count c
	task automatic push_message(input int n, input logic [3:0] c);
		int i;
		for (i = 0; i < n; i++)
			push_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
		push_word(rand64(), c, 1'b1);
	endtask

	// wait until every word is taken and every hash has come back
	task automatic drain();
		do
			@(posedge clk);
		while (word_q.size() > 0 || in_valid || hash_q.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] v);
		cfg_valid <= 1'b1;
		seed_value <= v;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		sh_seed = v;
		cfg_valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		int p;
		int m;
		int n;
		int r;
		cfg_valid = 1'b0;
		seed_value = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_seed(64'd0);

		// directed: empty, every tail size but 6, saturated count, stripe edges
		push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
		push_word(64'h0, 4'd8, 1'b1);
		push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
		push_word(rand64(), 4'd3, 1'b1);
		push_word(rand64(), 4'd4, 1'b1);
		push_word(rand64(), 4'd7, 1'b1);
		push_word(rand64(), 4'd15, 1'b1);
		push_word(rand64(), 4'd9, 1'b1);
		push_message(3, 4'd8);
		push_message(3, 4'd0);
		push_message(3, 4'd5);
		push_message(2, 4'd8);
		push_message(7, 4'd8);
		push_message(4, 4'd2);
		drain();

		for (p = 0; p < 10; p++) begin
			case (p % 5)
				0: write_seed(64'hFFFF_FFFF_FFFF_FFFF);
				1: write_seed(64'd0);
				2: write_seed(PR1);
				default: write_seed(rand64());
			endcase
			no_idle = (p % 4 == 3);
			// hold the sender back until this phase is queued
			hold_input = 1;
			for (m = 0; m < 28; m++) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					n = $urandom_range(0, 8);
				else if (r < 97)
					n = $urandom_range(9, 16);
				else
					n = $urandom_range(17, 40);
				push_message(n, 4'($urandom_range(0, 15)));
			end
			hold_input = 0;
			drain();
		end
		no_idle = 0;

		if (error_count == 0)
			$display("xxhash64_stream_hasher regression: pass");
		else
			$display("xxhash64_stream_hasher regression: fail");
		$finish;
	end

endmodule
